>>> design/tree_path_min_max_edge_query_top_assert.svh
// Assertion macros for the tree path query block.
`ifndef TREE_PATH_MIN_MAX_EDGE_QUERY_TOP_ASSERT_SVH
`define TREE_PATH_MIN_MAX_EDGE_QUERY_TOP_ASSERT_SVH
`define TPQ_ASSERT_IMPL(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define TPQ_ASSERT_NEXT(lbl, clk, rstn, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) else $error(msg);
`endif

>>> design/tpq_pkg.sv
// ----------------------------------------------------------------------------
// tpq_pkg
// Shared types and constants of the tree path min/max edge query block.
// ----------------------------------------------------------------------------
package tpq_pkg;
  localparam int unsigned NodeW = 17;
  localparam int unsigned EdgeW = 20;
  localparam int unsigned TimeW = 19;
  localparam logic [EdgeW-1:0] EdgeCap = 20'd1000000;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [NodeW-1:0] node_index;
    logic [NodeW-1:0] parent_node;
    logic [EdgeW-1:0] edge_len;
    logic [TimeW-1:0] enter_time;
    logic [TimeW-1:0] leave_time;
    logic [NodeW-1:0] other_node;
  } item_t;

  typedef struct packed {
    logic [EdgeW-1:0] min_edge;
    logic [EdgeW-1:0] max_edge;
  } result_t;

  typedef struct packed {
    logic [NodeW-1:0] anc;
    logic [EdgeW-1:0] mn;
    logic [EdgeW-1:0] mx;
  } jump_t;

  typedef struct packed {
    logic [TimeW-1:0] tin;
    logic [TimeW-1:0] tout;
  } times_t;
endpackage

>>> design/tpq_jump_mem.sv
// ----------------------------------------------------------------------------
// tpq_jump_mem
// Lifting table memory: one write port and one registered read port.
// ----------------------------------------------------------------------------
module tpq_jump_mem #(
  parameter int unsigned Depth = 4,
  parameter int unsigned AddrW = 2
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AddrW-1:0]      waddr_i,
  input  tpq_pkg::jump_t        wdata_i,
  input  logic [AddrW-1:0]      raddr_i,
  output tpq_pkg::jump_t        rdata_o
);
  tpq_pkg::jump_t mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

>>> design/tpq_time_mem.sv
// ----------------------------------------------------------------------------
// tpq_time_mem
// Entry and exit time memory: one write port and one registered read port.
// ----------------------------------------------------------------------------
module tpq_time_mem #(
  parameter int unsigned Depth = 4,
  parameter int unsigned AddrW = 2
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AddrW-1:0]      waddr_i,
  input  tpq_pkg::times_t       wdata_i,
  input  logic [AddrW-1:0]      raddr_i,
  output tpq_pkg::times_t       rdata_o
);
  tpq_pkg::times_t mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

>>> design/tree_path_min_max_edge_query_top.sv
// ----------------------------------------------------------------------------
// tree_path_min_max_edge_query_top
// Binary lifting path min/max edge query over a host-loaded tree.
// ----------------------------------------------------------------------------
// One item is taken at a time while busy is low. With L the levels walked
// (the configured level count, held to at most 17), a load keeps the block busy
// while it builds L further rows, and a query while it walks L lifting steps.
// Every lifting step goes one access at a time through the single read ports
// of the row memory and the time memory. A query with equal endpoints gives its
// result in the cycle after the transfer. A result appears on result_o for
// exactly one cycle with done_o high, and the next item can be taken in that
// same cycle; the receiver cannot stall it, so it must take every transfer.
module tree_path_min_max_edge_query_top #(
  parameter int unsigned MAX_NODES = 131072,
  parameter int unsigned LEVELS    = 18
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  tpq_pkg::item_t   item_i,
  output logic             done_o,
  output tpq_pkg::result_t result_o,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [4:0]       cfg_data_i
);
  localparam int unsigned NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned LW = $clog2(LEVELS);
  localparam int unsigned RW = NW + LW;
  localparam int unsigned NodeW = tpq_pkg::NodeW;
  localparam int unsigned EdgeW = tpq_pkg::EdgeW;
  localparam logic [4:0] LevMax = 5'(LEVELS - 1);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_LRD   = 11'b00000000010,
    S_LMID  = 11'b00000000100,
    S_LWR   = 11'b00000001000,
    S_QRA   = 11'b00000010000,
    S_QTA   = 11'b00000100000,
    S_QCA   = 11'b00001000000,
    S_QRB   = 11'b00010000000,
    S_QTB   = 11'b00100000000,
    S_QCB   = 11'b01000000000,
    S_FIN   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic [4:0] lev_cfg_q;
  logic [4:0] k_q, k_d, lv_q, lv_d;
  logic [NodeW-1:0] a_q, a_d, b_q, b_d, v_q, v_d;
  logic [EdgeW-1:0] lo_q, lo_d, hi_q, hi_d;
  tpq_pkg::jump_t prev_q, prev_d, cand_q, cand_d;
  logic [2:0] ph_q, ph_d;
  logic [NodeW-1:0] a0_q, a0_d;
  logic [EdgeW-1:0] amn_q, amn_d, amx_q, amx_d;
  logic done_q, done_d;
  tpq_pkg::result_t res_q, res_d;

  logic jwe, twe;
  logic [RW-1:0] jwa, jra;
  tpq_pkg::jump_t jwd, jrd;
  logic [NW-1:0] twa, tra;
  tpq_pkg::times_t twd, trd;
  tpq_pkg::times_t tnode_q, tnode_d;

  function automatic logic [RW-1:0] rowa(input logic [NodeW-1:0] n, input logic [4:0] l);
    rowa = RW'(NW'(n) * LEVELS) + RW'(l);
  endfunction

  tpq_jump_mem #(.Depth(MAX_NODES * LEVELS), .AddrW(RW)) u_jump (
    .clk_i(clk_i), .we_i(jwe), .waddr_i(jwa), .wdata_i(jwd), .raddr_i(jra), .rdata_o(jrd)
  );
  tpq_time_mem #(.Depth(MAX_NODES), .AddrW(NW)) u_time (
    .clk_i(clk_i), .we_i(twe), .waddr_i(twa), .wdata_i(twd), .raddr_i(tra), .rdata_o(trd)
  );

  assign busy = (state_q != S_IDLE);
  assign cfg_ready = !busy;
  assign done_o = done_q;
  assign result_o = res_q;

  logic in_range, q_above;
  logic [EdgeW-1:0] len_sat;
  assign in_range = (32'(item_i.node_index) < MAX_NODES) && (32'(item_i.parent_node) < MAX_NODES);
  assign len_sat = (item_i.edge_len > tpq_pkg::EdgeCap) ? tpq_pkg::EdgeCap : item_i.edge_len;
  assign q_above = (trd.tin <= tnode_q.tin) && (trd.tout >= tnode_q.tout);

  always_comb begin
    state_d = state_q; k_d = k_q; lv_d = lv_q; a_d = a_q; b_d = b_q; v_d = v_q;
    lo_d = lo_q; hi_d = hi_q; prev_d = prev_q; cand_d = cand_q; ph_d = ph_q;
    a0_d = a0_q; amn_d = amn_q; amx_d = amx_q; tnode_d = tnode_q;
    done_d = 1'b0; res_d = res_q;
    jwe = 1'b0; jwa = rowa(v_q, k_q); jwd = prev_q; jra = rowa(v_q, k_q);
    twe = 1'b0; twa = NW'(item_i.node_index);
    twd = '{tin: item_i.enter_time, tout: item_i.leave_time}; tra = NW'(b_q);
    case (state_q)
      S_IDLE: begin
        lv_d = (lev_cfg_q > LevMax) ? LevMax : lev_cfg_q;
        if (start) begin
          if (item_i.op == tpq_pkg::OP_LOAD) begin
            if (in_range) begin
              twe = 1'b1;
              v_d = item_i.node_index;
              prev_d = '{anc: item_i.parent_node,
                         mn: (len_sat == '0) ? tpq_pkg::EdgeCap : len_sat, mx: len_sat};
              jwe = 1'b1; jwa = rowa(item_i.node_index, 5'd0);
              jwd = prev_d;
              k_d = 5'd1;
              state_d = (lv_d == 5'd0) ? S_IDLE : S_LRD;
            end
          end else begin
            a_d = item_i.node_index; b_d = item_i.other_node;
            lo_d = tpq_pkg::EdgeCap; hi_d = '0;
            if (32'(item_i.node_index) >= MAX_NODES || 32'(item_i.other_node) >= MAX_NODES
                || item_i.node_index == item_i.other_node) begin
              done_d = 1'b1; res_d = '0;
            end else begin
              k_d = lv_d; state_d = (lv_d == 5'd0) ? S_FIN : S_QRA; ph_d = 3'd0;
            end
          end
        end
      end
      S_LRD: begin
        jra = rowa(prev_q.anc, k_q - 5'd1);
        state_d = S_LMID;
      end
      S_LMID: begin
        jra = rowa(prev_q.anc, k_q - 5'd1);
        state_d = S_LWR;
      end
      S_LWR: begin
        jwe = 1'b1; jwa = rowa(v_q, k_q);
        jwd = '{anc: jrd.anc, mn: (jrd.mn < prev_q.mn) ? jrd.mn : prev_q.mn,
                mx: (jrd.mx > prev_q.mx) ? jrd.mx : prev_q.mx};
        prev_d = jwd;
        k_d = k_q + 5'd1;
        state_d = (k_q >= lv_q) ? S_IDLE : S_LRD;
      end
      // Step for a: read row, then times of its ancestor, then check against b.
      S_QRA: begin
        jra = rowa(a_q, k_q - 5'd1); tra = NW'(b_q);
        ph_d = ph_q + 3'd1;
        if (ph_q == 3'd1) begin cand_d = jrd; tnode_d = trd; state_d = S_QTA; ph_d = 3'd0; end
      end
      S_QTA: begin
        tra = NW'(cand_q.anc);
        ph_d = ph_q + 3'd1;
        if (ph_q == 3'd1) state_d = S_QCA;
      end
      S_QCA: begin
        if (!q_above) begin
          lo_d = (cand_q.mn < lo_q) ? cand_q.mn : lo_q;
          hi_d = (cand_q.mx > hi_q) ? cand_q.mx : hi_q;
          a_d = cand_q.anc;
        end
        ph_d = 3'd0; state_d = S_QRB;
      end
      S_QRB: begin
        jra = rowa(b_q, k_q - 5'd1); tra = NW'(a_q);
        ph_d = ph_q + 3'd1;
        if (ph_q == 3'd1) begin cand_d = jrd; tnode_d = trd; state_d = S_QTB; ph_d = 3'd0; end
      end
      S_QTB: begin
        tra = NW'(cand_q.anc);
        ph_d = ph_q + 3'd1;
        if (ph_q == 3'd1) state_d = S_QCB;
      end
      S_QCB: begin
        if (!q_above) begin
          lo_d = (cand_q.mn < lo_q) ? cand_q.mn : lo_q;
          hi_d = (cand_q.mx > hi_q) ? cand_q.mx : hi_q;
          b_d = cand_q.anc;
        end
        ph_d = 3'd0; k_d = k_q - 5'd1;
        state_d = (k_q == 5'd1) ? S_FIN : S_QRA;
      end
      S_FIN: begin
        ph_d = ph_q + 3'd1;
        case (ph_q)
          3'd0: jra = rowa(a_q, 5'd0);
          3'd1: begin
            jra = rowa(b_q, 5'd0);
            a0_d = jrd.anc; amn_d = jrd.mn; amx_d = jrd.mx;
          end
          default: begin
            if (jrd.anc == a_q) begin
              lo_d = (jrd.mn < lo_q) ? jrd.mn : lo_q;
              hi_d = (jrd.mx > hi_q) ? jrd.mx : hi_q;
            end else if (a0_q == b_q) begin
              lo_d = (amn_q < lo_q) ? amn_q : lo_q;
              hi_d = (amx_q > hi_q) ? amx_q : hi_q;
            end else begin
              lo_d = (amn_q < lo_q) ? amn_q : lo_q;
              hi_d = (amx_q > hi_q) ? amx_q : hi_q;
              if (jrd.mn < lo_d) lo_d = jrd.mn;
              if (jrd.mx > hi_d) hi_d = jrd.mx;
            end
            done_d = 1'b1;
            res_d = '{min_edge: lo_d, max_edge: hi_d};
            state_d = S_IDLE;
          end
        endcase
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      lev_cfg_q <= 5'd17;
      done_q <= 1'b0;
      ph_q <= 3'd0;
      k_q <= 5'd0;
      lv_q <= 5'd0;
    end else begin
      state_q <= state_d;
      done_q <= done_d;
      ph_q <= ph_d;
      k_q <= k_d;
      lv_q <= lv_d;
      if (cfg_valid && cfg_ready) begin
        lev_cfg_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; v_q <= v_d; lo_q <= lo_d; hi_q <= hi_d;
    prev_q <= prev_d; cand_q <= cand_d; a0_q <= a0_d;
    amn_q <= amn_d; amx_q <= amx_d; tnode_q <= tnode_d; res_q <= res_d;
  end

`include "tree_path_min_max_edge_query_top_assert.svh"
  `TPQ_ASSERT_IMPL(a_onehot, clk_i, rst_ni, $onehot(state_q), "state not one-hot")
  `TPQ_ASSERT_NEXT(a_done_pulse, clk_i, rst_ni, done_q && state_q == S_IDLE && !start,
                   !done_q, "result strobe held")
  `TPQ_ASSERT_IMPL(a_cfg_idle, clk_i, rst_ni, !(cfg_ready && busy), "config open while busy")
  `TPQ_ASSERT_NEXT(a_lvl, clk_i, rst_ni, busy, lv_q <= LevMax, "level count out of range")
endmodule

>>> tb/tree_path_min_max_edge_query_top_test.sv
// ----------------------------------------------------------------------------
// tree_path_min_max_edge_query_top_test
// Self-checking test of the tree path min/max edge query block. Random trees
// are loaded in depth-first preorder and then queried for the least and
// greatest edge on tree paths. The level count is changed between trees.
// A local lifting predictor computes each expected result, and every result
// is checked in full, in order.
// ----------------------------------------------------------------------------
module tree_path_min_max_edge_query_top_test;

  localparam int unsigned NodeW = tpq_pkg::NodeW;
  localparam int unsigned EdgeW = tpq_pkg::EdgeW;
  localparam int unsigned TimeW = tpq_pkg::TimeW;
  localparam int unsigned TopLevel = 17;
  localparam int unsigned IdleLimit = 2000;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             start;
  logic             busy;
  tpq_pkg::item_t   item_i;
  logic             done_o;
  tpq_pkg::result_t result_o;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [4:0]       cfg_data_i;

  tree_path_min_max_edge_query_top u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .item_i    (item_i),
    .done_o    (done_o),
    .result_o  (result_o),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Predictor state: lifting rows keyed by node and level, DFS times by node.
  logic [NodeW-1:0] lift_anc[int unsigned];
  logic [EdgeW-1:0] lift_min[int unsigned];
  logic [EdgeW-1:0] lift_max[int unsigned];
  logic [TimeW-1:0] node_tin[int unsigned];
  logic [TimeW-1:0] node_tout[int unsigned];
  logic [4:0]       levels_setting = 5'd17;

  tpq_pkg::result_t path_edges_expected[$];
  int      mismatches = 0;
  int      results_seen = 0;
  int      loads_sent = 0;
  int      queries_sent = 0;
  int      settings_used = 0;
  int      idle_cycles = 0;
  int      max_gap = 5;

  int          tree_ids[$];
  int          tree_par[$];
  int          tree_edge[$];

  function automatic int unsigned row_key(logic [NodeW-1:0] node, int unsigned lvl);
    return {node, 5'b0} + lvl;
  endfunction

  function automatic int unsigned walk_levels();
    return (levels_setting > TopLevel) ? TopLevel : levels_setting;
  endfunction

  function automatic bit covers(logic [NodeW-1:0] a, logic [NodeW-1:0] b);
    return node_tin[a] <= node_tin[b] && node_tout[a] >= node_tout[b];
  endfunction

  function automatic void predict_load(tpq_pkg::item_t it);
    logic [NodeW-1:0] v;
    logic [NodeW-1:0] mid;
    logic [EdgeW-1:0] len;
    int unsigned      lv;
    v = it.node_index;
    lv = walk_levels();
    len = (it.edge_len > tpq_pkg::EdgeCap) ? tpq_pkg::EdgeCap : it.edge_len;
    node_tin[v] = it.enter_time;
    node_tout[v] = it.leave_time;
    lift_anc[row_key(v, 0)] = it.parent_node;
    lift_min[row_key(v, 0)] = (len == 0) ? tpq_pkg::EdgeCap : len;
    lift_max[row_key(v, 0)] = len;
    for (int unsigned i = 1; i <= lv; i++) begin
      mid = lift_anc[row_key(v, i - 1)];
      lift_anc[row_key(v, i)] = lift_anc[row_key(mid, i - 1)];
      lift_min[row_key(v, i)] = (lift_min[row_key(mid, i - 1)] < lift_min[row_key(v, i - 1)])
                              ? lift_min[row_key(mid, i - 1)] : lift_min[row_key(v, i - 1)];
      lift_max[row_key(v, i)] = (lift_max[row_key(mid, i - 1)] > lift_max[row_key(v, i - 1)])
                              ? lift_max[row_key(mid, i - 1)] : lift_max[row_key(v, i - 1)];
    end
  endfunction

  function automatic tpq_pkg::result_t predict_path(tpq_pkg::item_t it);
    logic [NodeW-1:0] a;
    logic [NodeW-1:0] b;
    logic [EdgeW-1:0] lo;
    logic [EdgeW-1:0] hi;
    int unsigned      k;
    tpq_pkg::result_t r;
    a = it.node_index;
    b = it.other_node;
    lo = tpq_pkg::EdgeCap;
    hi = '0;
    r = '0;
    if (a == b) return r;
    for (int unsigned i = walk_levels(); i > 0; i--) begin
      k = i - 1;
      if (!covers(lift_anc[row_key(a, k)], b)) begin
        if (lift_min[row_key(a, k)] < lo) lo = lift_min[row_key(a, k)];
        if (lift_max[row_key(a, k)] > hi) hi = lift_max[row_key(a, k)];
        a = lift_anc[row_key(a, k)];
      end
      if (!covers(lift_anc[row_key(b, k)], a)) begin
        if (lift_min[row_key(b, k)] < lo) lo = lift_min[row_key(b, k)];
        if (lift_max[row_key(b, k)] > hi) hi = lift_max[row_key(b, k)];
        b = lift_anc[row_key(b, k)];
      end
    end
    if (lift_anc[row_key(b, 0)] == a) begin
      if (lift_min[row_key(b, 0)] < lo) lo = lift_min[row_key(b, 0)];
      if (lift_max[row_key(b, 0)] > hi) hi = lift_max[row_key(b, 0)];
    end else if (lift_anc[row_key(a, 0)] == b) begin
      if (lift_min[row_key(a, 0)] < lo) lo = lift_min[row_key(a, 0)];
      if (lift_max[row_key(a, 0)] > hi) hi = lift_max[row_key(a, 0)];
    end else begin
      if (lift_min[row_key(a, 0)] < lo) lo = lift_min[row_key(a, 0)];
      if (lift_min[row_key(b, 0)] < lo) lo = lift_min[row_key(b, 0)];
      if (lift_max[row_key(a, 0)] > hi) hi = lift_max[row_key(a, 0)];
      if (lift_max[row_key(b, 0)] > hi) hi = lift_max[row_key(b, 0)];
    end
    r.min_edge = lo;
    r.max_edge = hi;
    return r;
  endfunction

  task automatic send_item(tpq_pkg::item_t it);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    if (it.op == tpq_pkg::OP_QUERY) begin
      path_edges_expected = {path_edges_expected, predict_path(it)};
      queries_sent++;
    end else begin
      predict_load(it);
      loads_sent++;
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (path_edges_expected.size() > 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_levels(logic [4:0] value);
    cfg_valid <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    levels_setting = value;
    settings_used++;
  endtask

  // Builds a random tree in preorder: each new node hangs below some node on
  // the path from the root to the previously added node.
  task automatic build_tree(int n);
    bit used[int];
    int path[$];
    int id;
    int pops;
    tree_ids.delete();
    tree_par.delete();
    tree_edge.delete();
    for (int i = 0; i < n; i++) begin
      do id = $urandom_range(0, 131071); while (used.exists(id));
      used[id] = 1'b1;
      tree_ids = {tree_ids, id};
      if (i == 0) begin
        tree_par = {tree_par, 0};
        tree_edge = {tree_edge, 0};
      end else begin
        pops = $urandom_range(0, (path.size() > 3) ? 3 : path.size() - 1);
        repeat (pops) void'(path.pop_back());
        tree_par = {tree_par, path[path.size() - 1]};
        case ($urandom_range(0, 9))
          0:       tree_edge = {tree_edge, int'($urandom_range(1000001, 1048575))};
          1:       tree_edge = {tree_edge, int'($urandom_range(0, 1048575))};
          2:       tree_edge = {tree_edge, 1000000};
          default: tree_edge = {tree_edge, int'($urandom_range(1, 1000000))};
        endcase
      end
      path = {path, i};
    end
  endtask

  task automatic load_tree(bit high_times);
    int    n;
    int    sz[$];
    int    stride;
    int    base;
    tpq_pkg::item_t it;
    n = tree_ids.size();
    sz = {};
    for (int i = 0; i < n; i++) sz = {sz, 1};
    for (int i = n - 1; i > 0; i--) sz[tree_par[i]] += sz[i];
    stride = $urandom_range(1, 262143 / n);
    base = high_times ? 262144 - n * stride : $urandom_range(0, 262144 - n * stride);
    for (int i = 0; i < n; i++) begin
      it.op = tpq_pkg::OP_LOAD;
      it.node_index = NodeW'(tree_ids[i]);
      it.parent_node = NodeW'(tree_ids[tree_par[i]]);
      it.edge_len = EdgeW'(tree_edge[i]);
      it.enter_time = TimeW'((i + 1) * stride + base);
      it.leave_time = TimeW'((i + sz[i]) * stride + base);
      it.other_node = NodeW'($urandom_range(0, 131071));
      send_item(it);
    end
  endtask

  task automatic query_pair(int a, int b);
    tpq_pkg::item_t it;
    it.op = tpq_pkg::OP_QUERY;
    it.node_index = NodeW'(a);
    it.other_node = NodeW'(b);
    it.parent_node = NodeW'($urandom_range(0, 131071));
    it.edge_len = EdgeW'($urandom_range(0, 1048575));
    it.enter_time = TimeW'($urandom_range(0, 524287));
    it.leave_time = TimeW'($urandom_range(0, 524287));
    send_item(it);
  endtask

  task automatic test_directed_tree();
    tree_ids = {131071, 0, 87381, 43690, 65536};
    tree_par = {0, 0, 1, 0, 3};
    tree_edge = {0, 1048575, 1, 1000000, 0};
    load_tree(1'b0);
    query_pair(0, 0);
    query_pair(131071, 0);
    query_pair(0, 131071);
    query_pair(87381, 43690);
    query_pair(65536, 87381);
    query_pair(87381, 131071);
    query_pair(43690, 65536);
    drain_results();
    query_pair(65536, 0);
    query_pair(131071, 131071);
  endtask

  task automatic test_tree_phase(logic [4:0] levels, int n, bit high_times);
    int a;
    int b;
    drain_results();
    write_levels(levels);
    max_gap = ($urandom_range(0, 3) == 0) ? 0 : 5;
    build_tree(n);
    load_tree(high_times);
    for (int q = 0; q < 2 * n; q++) begin
      a = tree_ids[$urandom_range(0, n - 1)];
      b = ($urandom_range(0, 9) == 0) ? a : tree_ids[$urandom_range(0, n - 1)];
      query_pair(a, b);
    end
  endtask

  task automatic test_level_settings();
    logic [4:0] fixed_levels[$];
    fixed_levels = {5'd1, 5'd0, 5'd31, 5'd17, 5'd18, 5'd2};
    foreach (fixed_levels[i]) test_tree_phase(fixed_levels[i], $urandom_range(2, 30), i == 2);
    test_tree_phase(5'd17, 200, 1'b1);
    while (loads_sent + queries_sent < 1700)
      test_tree_phase(5'($urandom_range(0, 31)), $urandom_range(2, 40),
                      $urandom_range(0, 3) == 0);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Timeout: no transfer for %0d cycles.", IdleLimit);
        $display("*** FAILED ***");
        $finish;
      end
      if (done_o) begin
        results_seen++;
        if (path_edges_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected result min=%0d max=%0d", result_o.min_edge, result_o.max_edge);
        end else begin
          if (result_o != path_edges_expected[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected min=%0d max=%0d, got min=%0d max=%0d",
                       path_edges_expected[0].min_edge, path_edges_expected[0].max_edge,
                       result_o.min_edge, result_o.max_edge);
          end
          void'(path_edges_expected.pop_front());
        end
      end
    end
  end

  initial begin
    rst_ni <= 1'b0;
    start <= 1'b0;
    item_i <= '0;
    cfg_valid <= 1'b0;
    cfg_data_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed_tree();
    test_level_settings();
    drain_results();
    repeat (200) @(posedge clk_i);
    $display("Covered %0d loads and %0d path queries (%0d results) over %0d level settings.",
             loads_sent, queries_sent, results_seen, settings_used);
    if (mismatches == 0 && path_edges_expected.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing.", mismatches, path_edges_expected.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
